// ===== hdl/aqd_pkg.sv =====
package aqd_pkg;

    // Default sizes of the sample and position fields.
    localparam int SAMPLE_BITS_DEFAULT   = 10;
    localparam int POSITION_BITS_DEFAULT = 16;

    // Configuration port geometry.
    localparam int CFG_BITS      = 10;
    localparam int CFG_ADDR_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_CLEARING_MARGIN  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PRIMING_MIDPOINT = 1'd1;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] MARGIN_RESET   = 10'd20;
    localparam logic [CFG_BITS-1:0] MIDPOINT_RESET = 10'd530;

    // Command carried in tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Two's complement step codes.
    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_FWD  = 2'b01;
    localparam logic [1:0] STEP_REV  = 2'b11;

endpackage

// ===== hdl/analog_quadrature_decoder_unit.sv =====
// Channel | Direction | Transaction contents
// s_      | in        | tuser: cmd; tdata: sample_a, sample_b, new_position
// m_      | out       | tdata: position, step, level_a, level_b
// cfg_    | in        | write of clearing_margin (index 0) or priming_midpoint (index 1)
//
// One item per cycle while m_tready does not stall the result. An accepted item
// is registered, then the hysteresis compares and the position increment run
// combinationally into the result register and the state, which drives m_tvalid.
// Reset clears the tracked values, levels, position and priming flag and
// restores the configuration defaults; no clearing pass is needed.
// A stalled result holds the input register, which then holds s_tready low.
module analog_quadrature_decoder_unit
    import aqd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // From bit 0: sample_a, sample_b, new_position, zero padding.
    input  logic [((2 * SAMPLE_BITS + POSITION_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Bit 0: cmd.
    input  logic [0:0]               s_tuser,
    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // From bit 0: position, step, level_a, level_b, zero padding.
    output logic [((POSITION_BITS + 4 + 7) / 8) * 8 - 1:0] m_tdata,
    // Configuration writes.
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data
);

    localparam int OUT_W = ((POSITION_BITS + 4 + 7) / 8) * 8;
    localparam int CW    = (SAMPLE_BITS < CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int CMP_W = SAMPLE_BITS + 1;

    typedef logic [SAMPLE_BITS-1:0]   sample_t;
    typedef logic [POSITION_BITS-1:0] pos_t;

    // Gray position of a level pair: 00, 01, 11, 10 map to 0..3.
    function automatic logic [1:0] gray_index(input logic a, input logic b);
        return {a, a ^ b};
    endfunction

    // Configuration registers.
    logic [CW-1:0] margin_reg;
    logic [CW-1:0] midpoint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg   <= CW'(MARGIN_RESET);
            midpoint_reg <= CW'(MIDPOINT_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CLEARING_MARGIN:  margin_reg   <= cfg_data[CW-1:0];
                REG_PRIMING_MIDPOINT: midpoint_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Input register and handshake.
    logic    in_valid_reg;
    logic    cmd_reg;
    sample_t sample_a_reg;
    sample_t sample_b_reg;
    pos_t    new_pos_reg;
    logic    out_valid_reg;
    logic    move;

    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg      <= s_tuser[0];
            sample_a_reg <= s_tdata[SAMPLE_BITS-1:0];
            sample_b_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            new_pos_reg  <= s_tdata[2*SAMPLE_BITS+POSITION_BITS-1:2*SAMPLE_BITS];
        end
    end

    // Decoder state.
    sample_t    track_a_reg, track_a_next;
    sample_t    track_b_reg, track_b_next;
    logic       high_a_reg, high_a_next;
    logic       high_b_reg, high_b_next;
    pos_t       count_reg, count_next;
    logic       primed_reg, primed_next;
    logic [1:0] step_reg, step_next;

    // Hysteresis decisions, thresholds taken one bit wider so they never wrap.
    logic [CMP_W-1:0] sa_w, sb_w, ta_w, tb_w, m_w, mid_w;
    logic             lvl_a, lvl_b;
    logic [1:0]       gray_diff;

    assign sa_w  = CMP_W'(sample_a_reg);
    assign sb_w  = CMP_W'(sample_b_reg);
    assign ta_w  = CMP_W'(track_a_reg);
    assign tb_w  = CMP_W'(track_b_reg);
    assign m_w   = CMP_W'(margin_reg);
    assign mid_w = CMP_W'(midpoint_reg);

    assign lvl_a = high_a_reg ? !(sa_w + m_w < ta_w) : (sa_w > ta_w + m_w);
    assign lvl_b = high_b_reg ? !(sb_w + m_w < tb_w) : (sb_w > tb_w + m_w);
    assign gray_diff = gray_index(lvl_a, lvl_b) - gray_index(high_a_reg, high_b_reg);

    // Next state for the item in the input register.
    always_comb begin
        track_a_next = track_a_reg;
        track_b_next = track_b_reg;
        high_a_next  = high_a_reg;
        high_b_next  = high_b_reg;
        count_next   = count_reg;
        primed_next  = primed_reg;
        step_next    = STEP_NONE;
        if (cmd_reg == CMD_LOAD) begin
            count_next = new_pos_reg;
        end else if (!primed_reg) begin
            track_a_next = sample_a_reg;
            track_b_next = sample_b_reg;
            high_a_next  = sa_w > mid_w;
            high_b_next  = sb_w > mid_w;
            primed_next  = 1'b1;
        end else begin
            high_a_next = lvl_a;
            high_b_next = lvl_b;
            if (lvl_a ? (sample_a_reg > track_a_reg) : (sample_a_reg < track_a_reg)) begin
                track_a_next = sample_a_reg;
            end
            if (lvl_b ? (sample_b_reg > track_b_reg) : (sample_b_reg < track_b_reg)) begin
                track_b_next = sample_b_reg;
            end
            case (gray_diff)
                2'd1: begin
                    step_next  = STEP_FWD;
                    count_next = count_reg + POSITION_BITS'(1);
                end
                2'd3: begin
                    step_next  = STEP_REV;
                    count_next = count_reg - POSITION_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    // State and result register advance together, so the result fields
    // read straight from the state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_a_reg   <= '0;
            track_b_reg   <= '0;
            high_a_reg    <= 1'b0;
            high_b_reg    <= 1'b0;
            count_reg     <= '0;
            primed_reg    <= 1'b0;
            step_reg      <= STEP_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (move) begin
                track_a_reg <= track_a_next;
                track_b_reg <= track_b_next;
                high_a_reg  <= high_a_next;
                high_b_reg  <= high_b_next;
                count_reg   <= count_next;
                primed_reg  <= primed_next;
                step_reg    <= step_next;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({high_b_reg, high_a_reg, step_reg, count_reg});

`ifndef ASSERT_OFF
    // A load transaction never reports a step.
    a_load_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        move && cmd_reg == CMD_LOAD |-> step_next == STEP_NONE)
        else $error("load command produced a step");

    // A step is only possible once the block is primed.
    a_step_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && step_reg != STEP_NONE |-> primed_reg)
        else $error("step reported before priming");

    // A step always comes with a change of the level pair.
    a_step_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        move && step_next != STEP_NONE
            |-> {high_a_next, high_b_next} != {high_a_reg, high_b_reg})
        else $error("step without level change");

    // A held input item is not dropped while the result side stalls.
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !move |=> in_valid_reg)
        else $error("pending item lost");
`endif

endmodule
